// ===== design/rtu_pkg.sv =====
// rtu_pkg: shared types, result kind codes, register indexes and CRC-16 helper
// for the RTU frame checker. No dependencies.
`timescale 1ns / 1ps

package rtu_pkg;

    // result kind codes
    typedef logic [2:0] t_kind;
    localparam t_kind KIND_CRC        = 3'd0;
    localparam t_kind KIND_ADDR       = 3'd1;
    localparam t_kind KIND_DISPATCH   = 3'd2;
    localparam t_kind KIND_SUPPRESSED = 3'd3;
    localparam t_kind KIND_REPLY      = 3'd4;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_DEV_ADDR = 2'd0;
    localparam t_cfg_idx CFG_FROZEN   = 2'd1;

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [7:0]  BROADCAST  = 8'h00;
    localparam logic [7:0]  EXC_FLAG   = 8'h80;
    localparam logic [7:0]  EXC_ILLEGAL_FUNC = 8'h01;
    localparam int          MIN_FRAME  = 4;

    // supported function codes
    localparam logic [7:0] FC_RD_HOLD   = 8'h03;
    localparam logic [7:0] FC_RD_INPUT  = 8'h04;
    localparam logic [7:0] FC_WR_COIL   = 8'h05;
    localparam logic [7:0] FC_WR_MULTI  = 8'h10;
    localparam logic [7:0] FC_USER_25   = 8'h25;
    localparam logic [7:0] FC_USER_26   = 8'h26;
    localparam logic [7:0] FC_USER_27   = 8'h27;
    localparam logic [7:0] FC_USER_2A   = 8'h2A;
    localparam logic [7:0] FC_USER_2B   = 8'h2B;
    localparam logic [7:0] FC_USER_41   = 8'h41;

    // verdict handed from the frame accumulator to the response sequencer
    typedef struct packed {
        t_kind      kind;
        logic [7:0] func_code;
        logic [7:0] addr;
    } t_verdict;

    // one byte of CRC-16/MODBUS, bitwise, reflected
    function automatic logic [15:0] crc_upd(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic code_supported(input logic [7:0] c);
        logic ok;
        case (c) inside
            FC_RD_HOLD, FC_RD_INPUT, FC_WR_COIL, FC_WR_MULTI, FC_USER_25,
            FC_USER_26, FC_USER_27, FC_USER_2A, FC_USER_2B, FC_USER_41: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

// ===== design/rtu_if.sv =====
// rtu_if: valid/ready channel interfaces for received bytes, results and
// configuration writes. Depends on rtu_pkg.
`timescale 1ns / 1ps

interface rtu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_end;

    modport source (output valid, output rx_byte, output frame_end, input ready);
    modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface rtu_out_if;
    logic             valid;
    logic             ready;
    rtu_pkg::t_kind   kind;
    logic [7:0]       tx_byte;
    logic [7:0]       func_code;
    logic             last;

    modport source (output valid, output kind, output tx_byte, output func_code,
                    output last, input ready);
    modport sink   (input valid, input kind, input tx_byte, input func_code,
                    input last, output ready);
endinterface

interface rtu_cfg_if;
    logic                valid;
    logic                ready;
    rtu_pkg::t_cfg_idx   index;
    logic [7:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/rtu_frame_acc.sv =====
// rtu_frame_acc: per-byte CRC and header capture, frame verdict register.
// Depends on rtu_pkg and rtu_in_if.
`timescale 1ns / 1ps

module rtu_frame_acc #(
    parameter int MAX_FRAME = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rtu_in_if.sink            i_rx,
    input  logic [7:0]        i_dev_addr,
    input  logic              i_frozen,
    output logic              o_vd_valid,
    output rtu_pkg::t_verdict o_vd,
    input  logic              i_vd_take
);

    localparam int CNT_W = $clog2(MAX_FRAME + 2);

    logic [15:0]       r_crc;
    logic [CNT_W-1:0]  r_cnt;
    logic [7:0]        r_addr;
    logic [7:0]        r_code;
    logic              r_vd_valid;
    rtu_pkg::t_verdict r_vd;

    logic [15:0]       n_crc;
    logic [CNT_W-1:0]  n_cnt;
    logic [7:0]        n_addr;
    logic [7:0]        n_code;
    rtu_pkg::t_verdict n_vd;
    logic              fire;

    assign i_rx.ready = !r_vd_valid || i_vd_take;
    assign fire       = i_rx.valid && i_rx.ready;

    always_comb begin
        n_crc  = rtu_pkg::crc_upd(r_crc, i_rx.rx_byte);
        n_cnt  = (r_cnt <= CNT_W'(MAX_FRAME)) ? r_cnt + CNT_W'(1) : r_cnt;
        n_addr = (r_cnt == '0) ? i_rx.rx_byte : r_addr;
        n_code = (r_cnt == CNT_W'(1)) ? i_rx.rx_byte : r_code;

        n_vd.func_code = n_code;
        n_vd.addr      = n_addr;
        if (n_crc != 16'h0000 || n_cnt < CNT_W'(rtu_pkg::MIN_FRAME)
                || n_cnt > CNT_W'(MAX_FRAME)) begin
            n_vd.kind = rtu_pkg::KIND_CRC;
        end else if (n_addr != i_dev_addr && n_addr != rtu_pkg::BROADCAST) begin
            n_vd.kind = rtu_pkg::KIND_ADDR;
        end else if (rtu_pkg::code_supported(n_code)) begin
            n_vd.kind = rtu_pkg::KIND_DISPATCH;
        end else if (n_addr == rtu_pkg::BROADCAST || i_frozen) begin
            n_vd.kind = rtu_pkg::KIND_SUPPRESSED;
        end else begin
            n_vd.kind = rtu_pkg::KIND_REPLY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc      <= rtu_pkg::CRC_INIT;
            r_cnt      <= '0;
            r_addr     <= '0;
            r_code     <= '0;
            r_vd_valid <= 1'b0;
        end else begin
            if (fire && i_rx.frame_end) begin
                r_vd_valid <= 1'b1;
            end else if (i_vd_take) begin
                r_vd_valid <= 1'b0;
            end
            if (fire) begin
                if (i_rx.frame_end) begin
                    // frame closed: verdict out, state back to start
                    r_crc  <= rtu_pkg::CRC_INIT;
                    r_cnt  <= '0;
                    r_addr <= '0;
                    r_code <= '0;
                end else begin
                    r_crc  <= n_crc;
                    r_cnt  <= n_cnt;
                    r_addr <= n_addr;
                    r_code <= n_code;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && i_rx.frame_end) begin
            r_vd <= n_vd;
        end
    end

    assign o_vd_valid = r_vd_valid;
    assign o_vd       = r_vd;

endmodule

// ===== design/rtu_resp_seq.sv =====
// rtu_resp_seq: result register; turns a verdict into one result or a
// five-byte exception reply. Depends on rtu_pkg and rtu_out_if.
`timescale 1ns / 1ps

module rtu_resp_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vd_valid,
    input  rtu_pkg::t_verdict i_vd,
    output logic              o_vd_take,
    rtu_out_if.source         o_tx
);

    // reply byte positions after the address byte
    localparam logic [2:0] POS_CODE   = 3'd1;
    localparam logic [2:0] POS_EXC    = 3'd2;
    localparam logic [2:0] POS_CRC_LO = 3'd3;
    localparam logic [2:0] POS_CRC_HI = 3'd4;

    logic                r_valid;
    rtu_pkg::t_kind      r_kind;
    logic [7:0]          r_tx;
    logic [7:0]          r_fc;
    logic                r_last;
    logic                r_rep;
    logic [2:0]          r_pos;
    logic [15:0]         r_crc;

    logic                out_free;
    logic [7:0]          rep_byte;

    assign out_free  = !r_valid || o_tx.ready;
    assign o_vd_take = i_vd_valid && out_free && !r_rep;

    always_comb begin
        case (r_pos)
            POS_CODE:   rep_byte = r_fc | rtu_pkg::EXC_FLAG;
            POS_EXC:    rep_byte = rtu_pkg::EXC_ILLEGAL_FUNC;
            POS_CRC_LO: rep_byte = r_crc[7:0];
            POS_CRC_HI: rep_byte = r_crc[15:8];
            default:    rep_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rep   <= 1'b0;
            r_pos   <= '0;
        end else if (out_free) begin
            if (r_rep) begin
                r_valid <= 1'b1;
                r_pos   <= r_pos + 3'd1;
                if (r_pos == POS_CRC_HI) begin
                    r_rep <= 1'b0;
                end
            end else if (i_vd_valid) begin
                r_valid <= 1'b1;
                if (i_vd.kind == rtu_pkg::KIND_REPLY) begin
                    r_rep <= 1'b1;
                    r_pos <= POS_CODE;
                end
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    // payload; CRC runs along with the header bytes as they are loaded
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_rep) begin
                r_kind <= rtu_pkg::KIND_REPLY;
                r_tx   <= rep_byte;
                r_last <= (r_pos == POS_CRC_HI);
                if (r_pos == POS_CODE || r_pos == POS_EXC) begin
                    r_crc <= rtu_pkg::crc_upd(r_crc, rep_byte);
                end
            end else if (o_vd_take) begin
                r_kind <= i_vd.kind;
                r_fc   <= i_vd.func_code;
                if (i_vd.kind == rtu_pkg::KIND_REPLY) begin
                    r_tx   <= i_vd.addr;
                    r_last <= 1'b0;
                    r_crc  <= rtu_pkg::crc_upd(rtu_pkg::CRC_INIT, i_vd.addr);
                end else begin
                    r_tx   <= 8'h00;
                    r_last <= 1'b1;
                end
            end
        end
    end

    assign o_tx.valid     = r_valid;
    assign o_tx.kind      = r_kind;
    assign o_tx.tx_byte   = r_tx;
    assign o_tx.func_code = r_fc;
    assign o_tx.last      = r_last;

endmodule

// ===== design/rtu_frame_checker_responder.sv =====
// rtu_frame_checker_responder: top level, configuration registers and the
// accumulator/sequencer pair. Depends on rtu_pkg, rtu_if, rtu_frame_acc, rtu_resp_seq.
`timescale 1ns / 1ps

// Usage
//   i_rx  : received frame bytes, one word per byte, frame_end on the last byte.
//   o_tx  : results. A frame gives one word (crc discard, address discard,
//           dispatch, reply suppressed) or five reply words (kind 4) carrying
//           address, code|0x80, 0x01, CRC low, CRC high; last marks the final word.
//   i_cfg : register writes, always ready. Index 0 device address, index 1
//           frozen; other indexes are ignored. Write only while idle.
// Order: the frame-end byte's verdict is registered in the accumulator, then in
//   the result register; reply words follow one per cycle while o_tx is ready.
// Throughput: 1 byte per cycle. Bytes are taken every cycle unless a verdict
//   is held: then every byte waits until the sequencer takes that verdict,
//   i.e. while it is busy with a 5-word reply or o_tx is stalled.
// Reset: synchronous, active low. CRC back to 0xFFFF, counts and header cleared,
//   device address 1, frozen 0, no result pending.
// Stall: a held o_tx word is kept stable; one verdict queues behind it, and
//   i_rx stops taking bytes from the cycle after that frame end.

module rtu_frame_checker_responder #(
    parameter int MAX_FRAME = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rtu_in_if.sink     i_rx,
    rtu_out_if.source  o_tx,
    rtu_cfg_if.sink    i_cfg
);

    logic [7:0]        r_dev_addr;
    logic              r_frozen;

    logic              vd_valid;
    rtu_pkg::t_verdict vd;
    logic              vd_take;

    // config port never stalls
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= 8'h01;
            r_frozen   <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                rtu_pkg::CFG_DEV_ADDR: r_dev_addr <= i_cfg.data;
                rtu_pkg::CFG_FROZEN:   r_frozen   <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // byte side: CRC over each byte, header capture, verdict at frame end
    rtu_frame_acc #(
        .MAX_FRAME (MAX_FRAME)
    ) u_acc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx       (i_rx),
        .i_dev_addr (r_dev_addr),
        .i_frozen   (r_frozen),
        .o_vd_valid (vd_valid),
        .o_vd       (vd),
        .i_vd_take  (vd_take)
    );

    // result side: output register and exception reply sequencing
    rtu_resp_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vd_valid (vd_valid),
        .i_vd       (vd),
        .o_vd_take  (vd_take),
        .o_tx       (o_tx)
    );

endmodule

// ===== design/rtu_chk.sv =====
// rtu_chk: port-level checks on the result channel, bound to the top level.
// Depends on rtu_pkg.
`timescale 1ns / 1ps

module rtu_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 i_ready,
    input rtu_pkg::t_kind       i_kind,
    input logic [7:0]           i_tx_byte,
    input logic [7:0]           i_func_code,
    input logic                 i_last
);

    // only reply words carry a byte
    a_tx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind != rtu_pkg::KIND_REPLY |-> i_tx_byte == 8'h00)
        else $error("tx_byte nonzero outside reply");

    // single-word results always close the frame
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind != rtu_pkg::KIND_REPLY |-> i_last)
        else $error("non-reply result without last");

    // a taken non-final reply word is followed at once by the next reply word
    a_reply_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && i_kind == rtu_pkg::KIND_REPLY && !i_last
        |=> i_valid && i_kind == rtu_pkg::KIND_REPLY
            && i_func_code == $past(i_func_code))
        else $error("reply broken off");

    // a reply opens with address, then code with the exception flag
    a_reply_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && i_kind == rtu_pkg::KIND_REPLY && !i_last
            && i_tx_byte != (i_func_code | rtu_pkg::EXC_FLAG)
            && $past(!(i_valid && i_kind == rtu_pkg::KIND_REPLY))
        |=> i_tx_byte == (i_func_code | rtu_pkg::EXC_FLAG))
        else $error("reply code byte wrong");

endmodule

bind rtu_frame_checker_responder rtu_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_tx.valid),
    .i_ready     (o_tx.ready),
    .i_kind      (o_tx.kind),
    .i_tx_byte   (o_tx.tx_byte),
    .i_func_code (o_tx.func_code),
    .i_last      (o_tx.last)
);
